/* rtl/core/m3bp_pkg.sv */
package m3bp_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned TICK_W    = 16;
    localparam int unsigned TYPE_W    = 2;
    localparam int unsigned CHAN_W    = 5;
    localparam int unsigned OUT_DATA_W = 32;

    localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd500;

    localparam logic [3:0] HI_NOTE_OFF = 4'h8;
    localparam logic [3:0] HI_NOTE_ON  = 4'h9;
    localparam logic [3:0] HI_CONTROL  = 4'hB;

    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_STATUS = 2'd1,
        PH_DATA1  = 2'd2
    } t_phase;

    typedef enum logic [TYPE_W-1:0] {
        MT_NOTE_ON  = 2'd0,
        MT_NOTE_OFF = 2'd1,
        MT_CONTROL  = 2'd2
    } t_msg_type;

    typedef struct packed {
        logic                valid;
        t_msg_type           msg_type;
        logic [CHAN_W-1:0]   channel;
        logic [BYTE_W-1:0]   status_value;
        logic [BYTE_W-1:0]   first_data;
        logic [BYTE_W-1:0]   second_data;
    } t_event;

    function automatic logic is_wanted(input logic [BYTE_W-1:0] b);
        return (b[7:4] == HI_NOTE_OFF) || (b[7:4] == HI_NOTE_ON)
            || (b[7:4] == HI_CONTROL);
    endfunction

    function automatic t_msg_type kind_of(input logic [BYTE_W-1:0] s);
        t_msg_type k;
        case (s[7:4])
            HI_NOTE_ON:  k = MT_NOTE_ON;
            HI_NOTE_OFF: k = MT_NOTE_OFF;
            default:     k = MT_CONTROL;
        endcase
        return k;
    endfunction

endpackage

/* rtl/core/midi_three_byte_parser.sv */
// the event beat is registered and shows in the cycle after the accepted byte that completes a message
// throughput: one beat per cycle, bytes and ticks alike, unless stalled by the single output register
// the input is stalled only while an event waits in the output register and is not taken
// reset (synchronous, active low): parser idle, held bytes and tick count zero,
// timeout limit 500, output register empty
module midi_three_byte_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic [0:0]  s_axis_tuser,   // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [m3bp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // channel, status_value, first_data, second_data, zero fill
    output logic [m3bp_pkg::TYPE_W-1:0]     m_axis_tuser,   // msg_type
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [m3bp_pkg::TICK_W-1:0]     i_cfg_data
);
    import m3bp_pkg::*;

    logic [TICK_W-1:0]   r_timeout_limit;
    logic                s_accept;
    t_event              w_event;
    logic                r_out_valid;
    t_event              r_out;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_limit <= TIMEOUT_RESET;
        end else if (i_cfg_valid) begin
            r_timeout_limit <= i_cfg_data;
        end
    end

    m3bp_fsm u_fsm (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (s_accept),
        .i_req_type      (s_axis_tuser[0]),
        .i_data_byte     (s_axis_tdata),
        .i_timeout_limit (r_timeout_limit),
        .o_event         (w_event)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_out_valid <= w_event.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && w_event.valid) begin
            r_out <= w_event;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.msg_type;
    assign m_axis_tdata  = {3'b000, r_out.second_data, r_out.first_data,
                            r_out.status_value, r_out.channel};

    // a tick never makes an event
    a_tick_no_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && s_axis_tuser[0] == REQ_TICK) |-> !w_event.valid)
        else $error("event raised on a tick");

    // a completed message shows up as an event beat next cycle
    a_event_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && w_event.valid) |=> (m_axis_tvalid
            && m_axis_tdata[4:0] == $past(w_event.channel)
            && m_axis_tdata[28:21] == $past(s_axis_tdata)))
        else $error("completed message lost");

    // an event beat carries a mapped type and a channel in range
    a_out_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser != 2'd3 && m_axis_tdata[4:0] != 5'd0
            && m_axis_tdata[4:0] <= 5'd16))
        else $error("bad event fields");

endmodule

/* rtl/core/m3bp_fsm.sv */
module m3bp_fsm (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic                        i_req_type,
    input  logic [7:0]                  i_data_byte,
    input  logic [m3bp_pkg::TICK_W-1:0] i_timeout_limit,
    output m3bp_pkg::t_event            o_event
);
    import m3bp_pkg::*;

    t_phase              r_phase, n_phase;
    logic [BYTE_W-1:0]   r_status, n_status;
    logic [BYTE_W-1:0]   r_data, n_data;
    logic [TICK_W-1:0]   r_ticks, n_ticks;

    // next state
    always_comb begin
        n_phase = r_phase;
        n_ticks = r_ticks;
        if (i_accept) begin
            if (i_req_type == REQ_TICK) begin
                if (r_ticks >= i_timeout_limit) begin
                    n_phase = PH_IDLE;
                    n_ticks = '0;
                end else begin
                    n_ticks = r_ticks + TICK_W'(1);
                end
            end else begin
                n_ticks = '0;
                case (r_phase)
                    PH_IDLE: begin
                        if (is_wanted(i_data_byte)) begin
                            n_phase = PH_STATUS;
                        end
                    end
                    PH_STATUS: n_phase = PH_DATA1;
                    PH_DATA1:  n_phase = PH_IDLE;
                    default:   n_phase = PH_IDLE;
                endcase
            end
        end
    end

    // outputs and held bytes
    always_comb begin
        n_status              = r_status;
        n_data                = r_data;
        o_event.valid         = 1'b0;
        o_event.msg_type      = kind_of(r_status);
        o_event.channel       = {1'b0, r_status[3:0]} + CHAN_W'(1);
        o_event.status_value  = r_status;
        o_event.first_data    = r_data;
        o_event.second_data   = i_data_byte;
        if (i_accept && (i_req_type == REQ_BYTE)) begin
            case (r_phase)
                PH_IDLE: begin
                    if (is_wanted(i_data_byte)) begin
                        n_status = i_data_byte;
                    end
                end
                PH_STATUS: n_data = i_data_byte;
                PH_DATA1:  o_event.valid = 1'b1;
                default:   o_event.valid = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_status <= '0;
            r_data   <= '0;
            r_ticks  <= '0;
        end else begin
            r_phase  <= n_phase;
            r_status <= n_status;
            r_data   <= n_data;
            r_ticks  <= n_ticks;
        end
    end

endmodule
